>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL. Build with NO_ASSERTIONS defined to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/cdq_pkg.sv
`default_nettype none

package cdq_pkg;

    localparam int WORD_W = 32;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_REAR  = 3'd1,
        OP_DEL_FRONT = 3'd2,
        OP_DEL_REAR  = 3'd3,
        OP_LIST      = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEL,
        S_LIST
    } t_state;

    // strobes from the controller to the slot store
    typedef struct packed {
        logic we;
        logic re;
    } t_ram_ctl;

endpackage

`default_nettype wire

>>> rtl/cdq_ram.sv
`default_nettype none

`include "assert_macros.svh"

module cdq_ram #(
    parameter int DEPTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire cdq_pkg::t_ram_ctl i_ctl,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire cdq_pkg::t_word    i_wdata,
    input  wire logic [AW-1:0]     i_raddr,
    output cdq_pkg::t_word         o_rdata
);

    cdq_pkg::t_word r_mem [DEPTH];
    cdq_pkg::t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while re is low, so a stalled list keeps its word
    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

    `ASSERT_ALWAYS(a_no_rw_same_cycle, i_clk, 1'b1, !(i_ctl.we && i_ctl.re),
        "slot store written and read in one cycle")
    `ASSERT_ALWAYS(a_waddr_range, i_clk, 1'b1, !i_ctl.we || (int'(i_waddr) < DEPTH),
        "write address beyond depth")
    `ASSERT_ALWAYS(a_raddr_range, i_clk, 1'b1, !i_ctl.re || (int'(i_raddr) < DEPTH),
        "read address beyond depth")

endmodule

`default_nettype wire

>>> rtl/circular_deque_unit.sv
`default_nettype none
// Circular deque of DEPTH 32-bit words.
// Input channel (i_valid/o_ready) carries an operation and a value; output
// channel (o_valid/i_ready) returns data, status and last for each result word.
// Insert, invalid operation and any empty/full report: the result is loaded
// into the output register at the accepting edge, so one item per cycle while the receiver keeps up.
// Delete: the slot is read from the synchronous store into its read register,
// then that word enters the output register; no new item is taken meanwhile.
// List: one stored word per cycle from front to rear while the receiver takes
// them, last set on the rear word; the walk uses the single read port.
// A single output register parts the two channels: a new item is taken while
// a result waits, as long as that result leaves in the same cycle or none
// waits. When the receiver stalls, the output holds and the walk pauses,
// and o_ready drops until the output register can take the next result.
// Reset (synchronous, active low) empties the deque and the output register;
// no clearing pass is needed, since slots are read only once written.
// Back-to-back accesses to one slot never overlap: the controller never writes
// and reads the store together and reads only after the writing edge has passed.

`include "assert_macros.svh"

module circular_deque_unit #(
    parameter int DEPTH = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [2:0]          i_operation,
    input  wire logic signed [31:0]  i_value,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic signed [31:0]       o_data,
    output logic [1:0]               o_status,
    output logic                     o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);

    cdq_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [AW-1:0]   r_tail, n_tail;
    logic [AW-1:0]   r_idx, n_idx;
    logic            r_empty, n_empty;
    logic            r_ov, n_ov;
    cdq_pkg::t_word  r_od, n_od;
    cdq_pkg::t_status r_os, n_os;
    logic            r_ol, n_ol;

    cdq_pkg::t_ram_ctl w_ctl;
    logic [AW-1:0]     w_waddr;
    logic [AW-1:0]     w_raddr;
    cdq_pkg::t_word    w_rdata;
    logic              w_in_acc;
    logic              w_out_free;
    logic              w_full;
    logic              w_load;
    logic              w_at_tail;

    function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ptr_prev(input logic [AW-1:0] p);
        return (p == '0) ? PTR_LAST : p - 1'b1;
    endfunction

    cdq_ram #(.DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_waddr (w_waddr),
        .i_wdata (i_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_out_free = !r_ov || i_ready;
    assign o_ready    = (r_state == cdq_pkg::S_IDLE) && w_out_free;
    assign w_in_acc   = i_valid && o_ready;
    assign w_full     = !r_empty && (ptr_next(r_tail) == r_head);
    assign w_at_tail  = (r_idx == r_tail);

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_tail  = r_tail;
        n_idx   = r_idx;
        n_empty = r_empty;
        w_ctl   = '0;
        w_waddr = r_head;
        w_raddr = r_head;
        w_load  = 1'b0;
        n_od    = r_od;
        n_os    = r_os;
        n_ol    = r_ol;

        unique case (r_state)
            cdq_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    w_load = 1'b1;
                    n_od   = '0;
                    n_os   = cdq_pkg::ST_OK;
                    n_ol   = 1'b1;
                    unique case (cdq_pkg::t_op'(i_operation)) inside
                        cdq_pkg::OP_INS_FRONT, cdq_pkg::OP_INS_REAR: begin
                            if (w_full) begin
                                n_os = cdq_pkg::ST_FULL;
                            end else begin
                                w_ctl.we = 1'b1;
                                if (r_empty) begin
                                    n_head  = '0;
                                    n_tail  = '0;
                                    n_empty = 1'b0;
                                    w_waddr = '0;
                                end else if (cdq_pkg::t_op'(i_operation)
                                             == cdq_pkg::OP_INS_FRONT) begin
                                    n_head  = ptr_prev(r_head);
                                    w_waddr = ptr_prev(r_head);
                                end else begin
                                    n_tail  = ptr_next(r_tail);
                                    w_waddr = ptr_next(r_tail);
                                end
                            end
                        end
                        cdq_pkg::OP_DEL_FRONT, cdq_pkg::OP_DEL_REAR: begin
                            if (r_empty) begin
                                n_os = cdq_pkg::ST_EMPTY;
                            end else begin
                                // word comes from the store next cycle
                                w_load   = 1'b0;
                                w_ctl.re = 1'b1;
                                n_state  = cdq_pkg::S_DEL;
                                if (r_head == r_tail) begin
                                    w_raddr = r_head;
                                    n_head  = '0;
                                    n_tail  = '0;
                                    n_empty = 1'b1;
                                end else if (cdq_pkg::t_op'(i_operation)
                                             == cdq_pkg::OP_DEL_FRONT) begin
                                    w_raddr = r_head;
                                    n_head  = ptr_next(r_head);
                                end else begin
                                    w_raddr = r_tail;
                                    n_tail  = ptr_prev(r_tail);
                                end
                            end
                        end
                        cdq_pkg::OP_LIST: begin
                            if (r_empty) begin
                                n_os = cdq_pkg::ST_EMPTY;
                            end else begin
                                w_load   = 1'b0;
                                w_ctl.re = 1'b1;
                                w_raddr  = r_head;
                                n_idx    = r_head;
                                n_state  = cdq_pkg::S_LIST;
                            end
                        end
                        default: begin
                            n_os = cdq_pkg::ST_INVALID;
                        end
                    endcase
                end
            end
            cdq_pkg::S_DEL: begin
                // output register is empty here: nothing was loaded at accept
                w_load  = 1'b1;
                n_od    = w_rdata;
                n_os    = cdq_pkg::ST_OK;
                n_ol    = 1'b1;
                n_state = cdq_pkg::S_IDLE;
            end
            cdq_pkg::S_LIST: begin
                if (w_out_free) begin
                    w_load = 1'b1;
                    n_od   = w_rdata;
                    n_os   = cdq_pkg::ST_OK;
                    n_ol   = w_at_tail;
                    if (w_at_tail) begin
                        n_state = cdq_pkg::S_IDLE;
                    end else begin
                        w_ctl.re = 1'b1;
                        w_raddr  = ptr_next(r_idx);
                        n_idx    = ptr_next(r_idx);
                    end
                end
            end
            default: begin
                n_state = cdq_pkg::S_IDLE;
            end
        endcase

        n_ov = w_load || (r_ov && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cdq_pkg::S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (w_load) begin
            r_od <= n_od;
            r_os <= n_os;
            r_ol <= n_ol;
        end
    end

    assign o_valid  = r_ov;
    assign o_data   = r_od;
    assign o_status = r_os;
    assign o_last   = r_ol;

    `ASSERT_ALWAYS(a_empty_ptrs, i_clk, i_rst_n,
        !r_empty || (r_head == '0 && r_tail == '0), "empty deque with pointers off zero")
    `ASSERT_ALWAYS(a_del_slot_free, i_clk, i_rst_n,
        (r_state != cdq_pkg::S_DEL) || !r_ov, "delete word arrives on a busy output")
    `ASSERT_NEXT(a_list_ends, i_clk, i_rst_n,
        (r_state == cdq_pkg::S_LIST) && w_out_free && w_at_tail,
        (r_state == cdq_pkg::S_IDLE) && r_ov && r_ol, "list walk did not close on rear word")
    `ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n,
        (r_state == cdq_pkg::S_LIST) && !w_out_free,
        $stable(r_idx) && $stable(w_rdata), "list walk moved while output stalled")

endmodule

`default_nettype wire

>>> tb/cdq_checker.sv
`default_nettype none

module cdq_checker #(
    parameter int DEPTH = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire logic [2:0]         i_in_operation,
    input  wire logic signed [31:0] i_in_value,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic signed [31:0] i_out_data,
    input  wire logic [1:0]         i_out_status,
    input  wire logic               i_out_last,
    output int                      o_errors,
    output int                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        cdq_pkg::t_word   data;
        cdq_pkg::t_status status;
        logic             last;
    } t_result;

    t_result deque_results[$];

    // shadow copy of the deque
    cdq_pkg::t_word slot_mem [DEPTH];
    int    head_idx;
    int    tail_idx;
    bit    deque_empty;
    int    error_count = 0;

    assign o_errors = error_count;

    task automatic report_mismatch(input string msg);
        $display("%0t cdq_checker: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic queue_result(input cdq_pkg::t_word data, input cdq_pkg::t_status status,
                                input logic last);
        t_result r;
        r.data   = data;
        r.status = status;
        r.last   = last;
        deque_results.push_back(r);
    endtask

    task automatic clear_deque();
        head_idx    = 0;
        tail_idx    = 0;
        deque_empty = 1'b1;
    endtask

    // works out the result words one accepted item causes and updates the shadow deque
    task automatic predict_deque_op(input logic [2:0] op, input cdq_pkg::t_word value);
        bit             is_full;
        bit             done;
        int             idx;
        int             n;
        cdq_pkg::t_word w;
        is_full = !deque_empty && ((tail_idx + 1) % DEPTH == head_idx);
        case (op) inside
            cdq_pkg::OP_INS_FRONT, cdq_pkg::OP_INS_REAR: begin
                if (is_full) begin
                    queue_result('0, cdq_pkg::ST_FULL, 1'b1);
                end else begin
                    if (deque_empty) begin
                        head_idx    = 0;
                        tail_idx    = 0;
                        deque_empty = 1'b0;
                        slot_mem[0] = value;
                    end else if (op == cdq_pkg::OP_INS_FRONT) begin
                        head_idx = (head_idx + DEPTH - 1) % DEPTH;
                        slot_mem[head_idx] = value;
                    end else begin
                        tail_idx = (tail_idx + 1) % DEPTH;
                        slot_mem[tail_idx] = value;
                    end
                    queue_result('0, cdq_pkg::ST_OK, 1'b1);
                end
            end
            cdq_pkg::OP_DEL_FRONT, cdq_pkg::OP_DEL_REAR: begin
                if (deque_empty) begin
                    queue_result('0, cdq_pkg::ST_EMPTY, 1'b1);
                end else begin
                    w = (op == cdq_pkg::OP_DEL_FRONT) ? slot_mem[head_idx]
                                                      : slot_mem[tail_idx];
                    if (head_idx == tail_idx)
                        clear_deque();
                    else if (op == cdq_pkg::OP_DEL_FRONT)
                        head_idx = (head_idx + 1) % DEPTH;
                    else
                        tail_idx = (tail_idx + DEPTH - 1) % DEPTH;
                    queue_result(w, cdq_pkg::ST_OK, 1'b1);
                end
            end
            cdq_pkg::OP_LIST: begin
                if (deque_empty) begin
                    queue_result('0, cdq_pkg::ST_EMPTY, 1'b1);
                end else begin
                    idx  = head_idx;
                    n    = 0;
                    done = 1'b0;
                    while (!done) begin
                        done = (idx == tail_idx) || (n == DEPTH - 1);
                        queue_result(slot_mem[idx], cdq_pkg::ST_OK, done);
                        idx = (idx + 1) % DEPTH;
                        n++;
                    end
                end
            end
            default: begin
                queue_result('0, cdq_pkg::ST_INVALID, 1'b1);
            end
        endcase
    endtask

    task automatic check_result_word();
        t_result want;
        if (deque_results.size() == 0) begin
            report_mismatch($sformatf("result word with none expected: data %0d status %0d",
                                      i_out_data, i_out_status));
        end else begin
            want = deque_results.pop_front();
            if (i_out_data !== want.data)
                report_mismatch($sformatf("data %0d, expected %0d", i_out_data, want.data));
            if (i_out_status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d",
                                          i_out_status, want.status));
            if (i_out_last !== want.last)
                report_mismatch($sformatf("last %0b, expected %0b", i_out_last, want.last));
        end
    endtask

    initial begin
        clear_deque();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_deque();
            deque_results.delete();
        end else begin
            // a result leaving at this edge belongs to an earlier word
            if (i_out_valid && i_out_ready)
                check_result_word();
            if (i_in_valid && i_in_ready)
                predict_deque_op(i_in_operation, i_in_value);
        end
        o_pending <= deque_results.size();
    end

endmodule

`default_nettype wire

>>> tb/tb_circular_deque_unit.sv
`default_nettype none

module tb_circular_deque_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 8;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic [2:0]         i_operation = cdq_pkg::OP_LIST;
    logic signed [31:0] i_value     = '0;
    logic               i_ready     = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic signed [31:0] o_data;
    logic [1:0]         o_status;
    logic               o_last;

    int error_total;
    int pending_results;
    int stall_left  = 0;
    bit rx_calm     = 1'b0;
    bit tx_calm     = 1'b0;

    circular_deque_unit #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_operation(i_operation),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .o_status   (o_status),
        .o_last     (o_last)
    );

    cdq_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_in_operation(i_operation),
        .i_in_value    (i_value),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_out_data    (o_data),
        .i_out_status  (o_status),
        .i_out_last    (o_last),
        .o_errors      (error_total),
        .o_pending     (pending_results)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: mostly short stalls, now and then a long one
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (rx_calm || $urandom_range(0, 99) < 70) begin
            i_ready <= 1'b1;
        end else begin
            i_ready    <= 1'b0;
            stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 50)
                                                       : $urandom_range(0, 2);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_calm || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic cdq_pkg::t_word pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // returns at the edge where the word is taken
    task automatic send_word(input logic [2:0] op, input cdq_pkg::t_word value);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_value     <= value;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
    endtask

    initial begin
        int          k;
        int          r;
        bit          fill_bias;
        logic [2:0]  op;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty deque: list, both deletes, the three invalid codes
        send_word(cdq_pkg::OP_LIST, '0);
        send_word(cdq_pkg::OP_DEL_FRONT, '1);
        send_word(cdq_pkg::OP_DEL_REAR, '0);
        send_word(3'd5, $urandom);
        send_word(3'd6, $urandom);
        send_word(3'd7, $urandom);
        // single word in and out at each end
        send_word(cdq_pkg::OP_INS_REAR, 32'h7FFF_FFFF);
        send_word(cdq_pkg::OP_DEL_REAR, '0);
        send_word(cdq_pkg::OP_INS_FRONT, 32'h8000_0000);
        send_word(cdq_pkg::OP_DEL_FRONT, '0);
        // fill from both ends so the pointers wrap, then overfill
        send_word(cdq_pkg::OP_INS_FRONT, '1);
        send_word(cdq_pkg::OP_INS_REAR, '0);
        send_word(cdq_pkg::OP_INS_FRONT, 32'h5555_5555);
        send_word(cdq_pkg::OP_INS_REAR, 32'hAAAA_AAAA);
        send_word(cdq_pkg::OP_INS_FRONT, 32'h0000_0001);
        send_word(cdq_pkg::OP_INS_REAR, 32'h8000_0000);
        send_word(cdq_pkg::OP_INS_FRONT, 32'h7FFF_FFFF);
        send_word(cdq_pkg::OP_INS_REAR, $urandom);
        send_word(cdq_pkg::OP_INS_REAR, $urandom);
        send_word(cdq_pkg::OP_INS_FRONT, $urandom);
        send_word(cdq_pkg::OP_LIST, '0);
        send_word(cdq_pkg::OP_DEL_FRONT, '0);
        send_word(cdq_pkg::OP_DEL_REAR, '0);
        send_word(cdq_pkg::OP_LIST, '0);
        wait_drained();

        fill_bias = 1'b1;
        for (k = 0; k < 250; k++) begin
            if (k % 25 == 0) begin
                fill_bias = 1'($urandom_range(0, 1));
                tx_calm   = ($urandom_range(0, 3) == 0);
                rx_calm  <= ($urandom_range(0, 3) == 0);
            end
            if (k % 60 == 59)
                wait_drained();
            r = $urandom_range(0, 99);
            if (r < 5)
                op = 3'($urandom_range(5, 7));
            else if (r < 15)
                op = cdq_pkg::OP_LIST;
            else if (r < (fill_bias ? 70 : 40))
                op = $urandom_range(0, 1) ? cdq_pkg::OP_INS_FRONT : cdq_pkg::OP_INS_REAR;
            else
                op = $urandom_range(0, 1) ? cdq_pkg::OP_DEL_FRONT : cdq_pkg::OP_DEL_REAR;
            send_word(op, pick_value());
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (error_total == 0 && pending_results == 0)
            $display("tb_circular_deque_unit: clean");
        else
            $display("tb_circular_deque_unit: errors");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb_circular_deque_unit: errors");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
+incdir+rtl
rtl/cdq_pkg.sv
rtl/cdq_ram.sv
rtl/circular_deque_unit.sv
tb/cdq_checker.sv
tb/tb_circular_deque_unit.sv
